// File: hw/rtl/ilff_pkg.sv
// Shared types, constants and helpers for the first-fit heap allocator.
package ilff_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int CHUNK_BYTES = 4096;
  localparam int HEAP_WORDS  = HEAP_BYTES / 4;
  localparam int WADDR_W     = $clog2(HEAP_WORDS);
  localparam int BRK_W       = $clog2(HEAP_BYTES) + 1;
  localparam int BP_W        = 34;
  localparam int BSZ_W       = 17;

  localparam int CHUNK_W4    = CHUNK_BYTES / 4;
  localparam int CHUNK_SZ    = (CHUNK_W4 + (CHUNK_W4 % 2)) * 4;
  localparam bit INIT_FITS   = (16 + CHUNK_SZ) <= HEAP_BYTES;
  localparam int BRK_RESET   = INIT_FITS ? 16 + CHUNK_SZ : 16;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BSZ_W-1:0]  bsize;
    logic [15:0]       addr;
  } item_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [5:0] {
    S_CLR, S_I0, S_I1, S_I2, S_I3, S_I4,
    S_IDLE,
    S_W_CHK, S_W_D,
    S_G_CHK, S_G_W0, S_G_W1, S_G_W2,
    S_F_A, S_F_AD, S_F_W0, S_F_W1,
    S_M_A, S_M_AD, S_M_B, S_M_BD, S_M_C, S_M_CD, S_M_S, S_M_W0, S_M_W1, S_M_END,
    S_P_A, S_P_AD, S_P_W0, S_P_W1, S_P_W2, S_P_W3
  } state_t;

  function automatic logic [WADDR_W-1:0] word_of(input logic [BP_W-1:0] a);
    return a[WADDR_W+1:2];
  endfunction

endpackage

// File: hw/rtl/implicit_list_first_fit_allocator.sv
// Heap allocator top level: first-fit walk over boundary-tagged blocks.
// Reset clears all 16384 heap words one word a cycle, which leaves the padding word zero,
// then states S_I0 to S_I4 lay down prologue, first chunk (if it fits) and epilogue before work starts.
// Ignored requests finish from idle, a free writes its tags and coalesces, an allocate walks
// the blocks, grows the heap when none fits, and reports out of memory when it cannot grow.
// One request at a time; the next starts once the result transfer is done.
module implicit_list_first_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_bytes[15:0], block_address[31:16]
  input  logic [0:0]  s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // result_address[15:0], status[17:16], zero[23:18]
);

  logic                  q_valid;
  logic                  q_ready;
  ilff_pkg::item_t       q_item;
  ilff_pkg::result_t     res;

  ilff_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  ilff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tdata = {6'b0, res.status, res.addr};

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:16] != ilff_pkg::ST_DONE) |-> m_tdata[15:0] == 16'd0)
    else $error("failed request carries an address");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] == 3'd0)
    else $error("result address not 8-byte aligned");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:16] != 2'd3)
    else $error("undefined status code");

endmodule

// File: hw/rtl/ilff_ram.sv
// Generic single-port RAM with registered read.
module ilff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hw/rtl/ilff_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module ilff_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [0:0]            s_tuser,
  output logic                  q_valid,
  output ilff_pkg::item_t       q_item,
  input  logic                  q_ready
);

  ilff_pkg::item_t slot [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  ilff_pkg::item_t cls;
  logic [16:0]     req_round;
  logic            push;
  logic            pop;

  always_comb begin
    req_round  = ({1'b0, s_tdata[15:0]} + 17'd7) & 17'h1FFF8;
    cls.bsize  = req_round + 17'd8;
    cls.addr   = s_tdata[31:16];
    if (s_tuser[0]) begin
      cls.kind = (s_tdata[31:16] == 16'd0) ? ilff_pkg::K_IGNORE : ilff_pkg::K_FREE;
    end else begin
      cls.kind = (s_tdata[15:0] == 16'd0) ? ilff_pkg::K_IGNORE : ilff_pkg::K_ALLOC;
    end
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/ilff_back.sv
// Back end: heap sequencer for walk, split, grow, coalesce and the clearing pass.
module ilff_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ilff_pkg::item_t       q_item,
  output logic                  q_ready,
  output logic                  res_valid,
  output ilff_pkg::result_t     res,
  input  logic                  res_ready
);

  ilff_pkg::state_t                  state;
  ilff_pkg::state_t                  state_next;
  logic [ilff_pkg::WADDR_W-1:0]      cnt;
  logic [ilff_pkg::BP_W-1:0]         bp;
  logic [31:0]                       sz;
  logic [31:0]                       psize;
  logic [31:0]                       nsize;
  logic [31:0]                       newsz;
  logic                              pfree;
  logic                              nfree;
  logic                              split;
  logic                              from_grow;
  logic [ilff_pkg::BSZ_W-1:0]        bsize;
  logic [ilff_pkg::BSZ_W-1:0]        gext;
  logic [ilff_pkg::BRK_W-1:0]        brk;
  logic                              out_v;
  ilff_pkg::result_t                 out_res;

  logic                              ram_en;
  logic                              ram_we;
  logic [ilff_pkg::WADDR_W-1:0]      ram_addr;
  logic [31:0]                       ram_wdata;
  logic [31:0]                       ram_rdata;
  logic [ilff_pkg::BP_W-1:0]         a;

  logic                              fin;
  ilff_pkg::result_t                 fin_res;
  logic                              take;

  logic [31:0]                       h_sz;
  logic [ilff_pkg::BP_W-1:0]         prev;
  logic [ilff_pkg::BP_W-1:0]         ret;
  logic [ilff_pkg::BSZ_W-1:0]        ext;
  logic [ilff_pkg::BRK_W:0]          brk_sum;
  logic                              split_now;
  logic [31:0]                       bsize32;
  logic [31:0]                       ext32;

  ilff_ram #(.WIDTH(32), .DEPTH(ilff_pkg::HEAP_WORDS)) u_heap (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign h_sz      = ram_rdata & ilff_pkg::SIZE_MASK;
  assign prev      = bp - {2'b0, psize};
  assign ret       = pfree ? prev : bp;
  assign ext       = (bsize > ilff_pkg::BSZ_W'(ilff_pkg::CHUNK_SZ)) ? bsize
                   : ilff_pkg::BSZ_W'(ilff_pkg::CHUNK_SZ);
  assign brk_sum   = {1'b0, brk} + (ilff_pkg::BRK_W + 1)'(ext);
  assign bsize32   = {15'b0, bsize};
  assign ext32     = {15'b0, gext};
  assign split_now = {2'b0, sz} >= ({17'b0, bsize} + 34'd16);
  assign take      = q_valid && q_ready;
  assign q_ready   = (state == ilff_pkg::S_IDLE) && !out_v;
  assign res_valid = out_v;
  assign res       = out_res;

  always_comb begin
    state_next = state;
    unique case (state)
      ilff_pkg::S_CLR:   if (&cnt) state_next = ilff_pkg::S_I0;
      ilff_pkg::S_I0:    state_next = ilff_pkg::S_I1;
      ilff_pkg::S_I1:    state_next = ilff_pkg::S_I2;
      ilff_pkg::S_I2:    state_next = ilff_pkg::INIT_FITS ? ilff_pkg::S_I3 : ilff_pkg::S_IDLE;
      ilff_pkg::S_I3:    state_next = ilff_pkg::S_I4;
      ilff_pkg::S_I4:    state_next = ilff_pkg::S_IDLE;
      ilff_pkg::S_IDLE: begin
        if (take) begin
          unique case (q_item.kind)
            ilff_pkg::K_ALLOC: state_next = ilff_pkg::S_W_CHK;
            ilff_pkg::K_FREE:  state_next = ilff_pkg::S_F_A;
            default:           state_next = ilff_pkg::S_IDLE;
          endcase
        end
      end
      ilff_pkg::S_W_CHK: state_next = (bp > {17'b0, brk}) ? ilff_pkg::S_G_CHK : ilff_pkg::S_W_D;
      ilff_pkg::S_W_D: begin
        if (h_sz == 32'd0) begin
          state_next = ilff_pkg::S_G_CHK;
        end else if (!ram_rdata[0] && (bsize32 <= h_sz)) begin
          state_next = ilff_pkg::S_P_A;
        end else begin
          state_next = ilff_pkg::S_W_CHK;
        end
      end
      ilff_pkg::S_G_CHK: state_next = (brk_sum > (ilff_pkg::BRK_W + 1)'(ilff_pkg::HEAP_BYTES))
                                      ? ilff_pkg::S_IDLE : ilff_pkg::S_G_W0;
      ilff_pkg::S_G_W0:  state_next = ilff_pkg::S_G_W1;
      ilff_pkg::S_G_W1:  state_next = ilff_pkg::S_G_W2;
      ilff_pkg::S_G_W2:  state_next = ilff_pkg::S_M_A;
      ilff_pkg::S_F_A:   state_next = ilff_pkg::S_F_AD;
      ilff_pkg::S_F_AD:  state_next = ilff_pkg::S_F_W0;
      ilff_pkg::S_F_W0:  state_next = ilff_pkg::S_F_W1;
      ilff_pkg::S_F_W1:  state_next = ilff_pkg::S_M_A;
      ilff_pkg::S_M_A:   state_next = ilff_pkg::S_M_AD;
      ilff_pkg::S_M_AD:  state_next = ilff_pkg::S_M_B;
      ilff_pkg::S_M_B:   state_next = ilff_pkg::S_M_BD;
      ilff_pkg::S_M_BD:  state_next = ilff_pkg::S_M_C;
      ilff_pkg::S_M_C:   state_next = ilff_pkg::S_M_CD;
      ilff_pkg::S_M_CD:  state_next = ilff_pkg::S_M_S;
      ilff_pkg::S_M_S:   state_next = (pfree || nfree) ? ilff_pkg::S_M_W0 : ilff_pkg::S_M_END;
      ilff_pkg::S_M_W0:  state_next = ilff_pkg::S_M_W1;
      ilff_pkg::S_M_W1:  state_next = ilff_pkg::S_M_END;
      ilff_pkg::S_M_END: state_next = (from_grow && (ret != '0)) ? ilff_pkg::S_P_A
                                      : ilff_pkg::S_IDLE;
      ilff_pkg::S_P_A:   state_next = ilff_pkg::S_P_AD;
      ilff_pkg::S_P_AD:  state_next = ilff_pkg::S_P_W0;
      ilff_pkg::S_P_W0:  state_next = ilff_pkg::S_P_W1;
      ilff_pkg::S_P_W1:  state_next = split ? ilff_pkg::S_P_W2 : ilff_pkg::S_IDLE;
      ilff_pkg::S_P_W2:  state_next = ilff_pkg::S_P_W3;
      ilff_pkg::S_P_W3:  state_next = ilff_pkg::S_IDLE;
      default:           state_next = ilff_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    a              = '0;
    ram_wdata      = 32'd0;
    fin            = 1'b0;
    fin_res.addr   = 16'd0;
    fin_res.status = ilff_pkg::ST_DONE;
    unique case (state)
      ilff_pkg::S_CLR: begin
        ram_en = 1'b1; ram_we = 1'b1; a = {18'b0, cnt, 2'b0};
      end
      ilff_pkg::S_I0: begin
        ram_en = 1'b1; ram_we = 1'b1; a = 34'd4; ram_wdata = 32'd9;
      end
      ilff_pkg::S_I1: begin
        ram_en = 1'b1; ram_we = 1'b1; a = 34'd8; ram_wdata = 32'd9;
      end
      ilff_pkg::S_I2: begin
        ram_en = 1'b1; ram_we = 1'b1; a = 34'd12;
        ram_wdata = ilff_pkg::INIT_FITS ? 32'(ilff_pkg::CHUNK_SZ) : 32'd1;
      end
      ilff_pkg::S_I3: begin
        ram_en = 1'b1; ram_we = 1'b1; a = 34'(16 + ilff_pkg::CHUNK_SZ - 8);
        ram_wdata = 32'(ilff_pkg::CHUNK_SZ);
      end
      ilff_pkg::S_I4: begin
        ram_en = 1'b1; ram_we = 1'b1; a = 34'(16 + ilff_pkg::CHUNK_SZ - 4);
        ram_wdata = 32'd1;
      end
      ilff_pkg::S_IDLE: begin
        if (take && (q_item.kind == ilff_pkg::K_IGNORE)) begin
          fin = 1'b1; fin_res.status = ilff_pkg::ST_IGNORED;
        end
      end
      ilff_pkg::S_W_CHK: begin
        ram_en = 1'b1; a = bp - 34'd4;
      end
      ilff_pkg::S_G_CHK: begin
        if (brk_sum > (ilff_pkg::BRK_W + 1)'(ilff_pkg::HEAP_BYTES)) begin
          fin = 1'b1; fin_res.status = ilff_pkg::ST_OOM;
        end
      end
      ilff_pkg::S_G_W0: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp - 34'd4; ram_wdata = ext32;
      end
      ilff_pkg::S_G_W1: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp + {2'b0, ext32} - 34'd8; ram_wdata = ext32;
      end
      ilff_pkg::S_G_W2: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp + {2'b0, ext32} - 34'd4; ram_wdata = 32'd1;
      end
      ilff_pkg::S_F_A, ilff_pkg::S_M_A, ilff_pkg::S_P_A: begin
        ram_en = 1'b1; a = bp - 34'd4;
      end
      ilff_pkg::S_F_W0: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp - 34'd4; ram_wdata = sz;
      end
      ilff_pkg::S_F_W1: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp + {2'b0, sz} - 34'd8; ram_wdata = sz;
      end
      ilff_pkg::S_M_B: begin
        ram_en = 1'b1; a = bp - 34'd8;
      end
      ilff_pkg::S_M_C: begin
        ram_en = 1'b1; a = bp + {2'b0, sz} - 34'd4;
      end
      ilff_pkg::S_M_W0: begin
        ram_en = 1'b1; ram_we = 1'b1; ram_wdata = newsz;
        if (pfree && nfree) a = prev - 34'd4;
        else if (nfree) a = bp - 34'd4;
        else a = bp + {2'b0, sz} - 34'd8;
      end
      ilff_pkg::S_M_W1: begin
        ram_en = 1'b1; ram_we = 1'b1; ram_wdata = newsz;
        if (pfree && nfree) a = bp + {2'b0, sz} + {2'b0, nsize} - 34'd8;
        else if (nfree) a = bp + {2'b0, newsz} - 34'd8;
        else a = prev - 34'd4;
      end
      ilff_pkg::S_M_END: begin
        if (!from_grow) begin
          fin = 1'b1;
        end else if (ret == '0) begin
          fin = 1'b1; fin_res.status = ilff_pkg::ST_OOM;
        end
      end
      ilff_pkg::S_P_W0: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp - 34'd4;
        ram_wdata = split_now ? (bsize32 | 32'd1) : (sz | 32'd1);
      end
      ilff_pkg::S_P_W1: begin
        ram_en = 1'b1; ram_we = 1'b1;
        a = bp + {2'b0, (split ? bsize32 : sz)} - 34'd8;
        ram_wdata = split ? (bsize32 | 32'd1) : (sz | 32'd1);
        if (!split) begin
          fin = 1'b1; fin_res.addr = bp[15:0];
        end
      end
      ilff_pkg::S_P_W2: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp + {2'b0, bsize32} - 34'd4;
        ram_wdata = sz - bsize32;
      end
      ilff_pkg::S_P_W3: begin
        ram_en = 1'b1; ram_we = 1'b1; a = bp + {2'b0, sz} - 34'd8;
        ram_wdata = sz - bsize32;
        fin = 1'b1; fin_res.addr = bp[15:0];
      end
      default: begin
      end
    endcase
    ram_addr = ilff_pkg::word_of(a);
  end

  always_ff @(posedge clk) begin
    if (fin) out_res <= fin_res;
    unique case (state)
      ilff_pkg::S_IDLE: begin
        if (take) begin
          bp    <= (q_item.kind == ilff_pkg::K_ALLOC) ? 34'd8 : {18'b0, q_item.addr};
          bsize <= q_item.bsize;
        end
      end
      ilff_pkg::S_W_D: begin
        // stay on the block that fits
        if (ram_rdata[0] || (bsize32 > h_sz)) bp <= bp + {2'b0, h_sz};
      end
      ilff_pkg::S_G_CHK: begin
        bp   <= {17'b0, brk};
        gext <= ext;
      end
      ilff_pkg::S_G_W2: from_grow <= 1'b1;
      ilff_pkg::S_F_W1: from_grow <= 1'b0;
      ilff_pkg::S_F_AD, ilff_pkg::S_M_AD, ilff_pkg::S_P_AD: sz <= h_sz;
      ilff_pkg::S_M_BD: begin
        psize <= h_sz;
        pfree <= !ram_rdata[0];
      end
      ilff_pkg::S_M_CD: begin
        nsize <= h_sz;
        nfree <= !ram_rdata[0];
      end
      ilff_pkg::S_M_S: begin
        if (pfree && nfree) newsz <= (sz + psize + nsize) & ilff_pkg::SIZE_MASK;
        else if (nfree) newsz <= (sz + nsize) & ilff_pkg::SIZE_MASK;
        else newsz <= (sz + psize) & ilff_pkg::SIZE_MASK;
      end
      ilff_pkg::S_M_END: bp <= ret;
      ilff_pkg::S_P_W0: split <= split_now;
      default: begin
      end
    endcase
    if (rst) begin
      state <= ilff_pkg::S_CLR;
      cnt   <= '0;
      brk   <= ilff_pkg::BRK_W'(ilff_pkg::BRK_RESET);
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ilff_pkg::S_CLR) cnt <= cnt + 1'b1;
      if (state == ilff_pkg::S_G_W2) brk <= brk + ilff_pkg::BRK_W'(gext);
      if (fin) out_v <= 1'b1;
      else if (out_v && res_ready) out_v <= 1'b0;
    end
  end

endmodule
